// ----- src/mr_pkg.sv -----
// shared constants and helpers for the miller-rabin round engine
// no dependencies
package mr_pkg;

  localparam int WORD_BITS = 63;
  localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  // (a + b) mod m for a, b < m
  function automatic word_t add_mod(input word_t a, input word_t b, input word_t m);
    logic [WORD_BITS:0] s;
    logic [WORD_BITS:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = s - {1'b0, m};
    return d[WORD_BITS] ? s[WORD_BITS-1:0] : d[WORD_BITS-1:0];
  endfunction

endpackage

// ----- src/mr_modred.sv -----
// bit-serial restoring reduction: rem = a mod m, one dividend bit per cycle
// depends on mr_pkg
module mr_modred (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  mr_pkg::word_t a,
  input  mr_pkg::word_t m,
  output logic          done,
  output mr_pkg::word_t rem
);

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_RUN  = 2'd1;
  localparam logic [1:0] R_FIN  = 2'd2;

  logic [1:0]     state;
  mr_pkg::word_t  asr;
  mr_pkg::word_t  mr;
  mr_pkg::cnt_t   cnt;
  logic [mr_pkg::WORD_BITS:0] t;
  logic [mr_pkg::WORD_BITS:0] d;

  assign t = {rem, asr[mr_pkg::WORD_BITS-1]};
  assign d = t - {1'b0, mr};
  assign done = (state == R_FIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
    end else begin
      unique case (state)
        R_IDLE, R_FIN: begin
          if (start) begin
            state <= R_RUN;
            rem   <= '0;
            asr   <= a;
            mr    <= m;
            cnt   <= mr_pkg::CNT_BITS'(mr_pkg::WORD_BITS);
          end else begin
            state <= R_IDLE;
          end
        end
        R_RUN: begin
          rem <= d[mr_pkg::WORD_BITS] ? t[mr_pkg::WORD_BITS-1:0] : d[mr_pkg::WORD_BITS-1:0];
          asr <= {asr[mr_pkg::WORD_BITS-2:0], 1'b0};
          cnt <= cnt - 1'b1;
          if (cnt == mr_pkg::CNT_BITS'(1)) state <= R_FIN;
        end
        default: state <= R_IDLE;
      endcase
    end
  end

endmodule

// ----- src/mr_modmul.sv -----
// bit-serial modular multiplier: acc = x * y mod m, msb of y first,
// a double step and an add step per bit; depends on mr_pkg
module mr_modmul (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  mr_pkg::word_t x,
  input  mr_pkg::word_t y,
  input  mr_pkg::word_t m,
  output logic          done,
  output mr_pkg::word_t acc
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_DBL  = 2'd1;
  localparam logic [1:0] M_ADD  = 2'd2;
  localparam logic [1:0] M_FIN  = 2'd3;

  logic [1:0]    state;
  mr_pkg::word_t xr;
  mr_pkg::word_t ysr;
  mr_pkg::word_t mr;
  mr_pkg::cnt_t  cnt;

  assign done = (state == M_FIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
    end else begin
      unique case (state)
        M_IDLE, M_FIN: begin
          if (start) begin
            state <= M_DBL;
            acc   <= '0;
            xr    <= x;
            ysr   <= y;
            mr    <= m;
            cnt   <= mr_pkg::CNT_BITS'(mr_pkg::WORD_BITS);
          end else begin
            state <= M_IDLE;
          end
        end
        M_DBL: begin
          acc   <= mr_pkg::add_mod(acc, acc, mr);
          state <= M_ADD;
        end
        M_ADD: begin
          if (ysr[mr_pkg::WORD_BITS-1]) acc <= mr_pkg::add_mod(acc, xr, mr);
          ysr <= {ysr[mr_pkg::WORD_BITS-2:0], 1'b0};
          cnt <= cnt - 1'b1;
          state <= (cnt == mr_pkg::CNT_BITS'(1)) ? M_FIN : M_DBL;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

// ----- src/miller_rabin_prime_test.sv -----
// miller-rabin round engine, one round per input transfer; depends on mr_pkg, mr_modred, mr_modmul
// round time depends on the clear and set bits of the odd part of candidate-1 and on the
// squarings (at most r = trailing zeros of candidate-1); trivially failing candidates (below 2
// or even other than 2) go straight to the final state, which an output stall can hold
// rounds are sequential: in_stall stays high until the round is back in idle, where a new input transfer is taken
// reset: synchronous, clears the controller and out_valid, sets the passing flag to 1
module miller_rabin_prime_test (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mr_pkg::WORD_BITS-1:0]  candidate,
  input  logic [mr_pkg::WORD_BITS-1:0]  witness,
  input  logic                          last_round,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          probably_prime
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_STRIP = 4'd1;
  localparam logic [3:0] S_RED   = 4'd2;
  localparam logic [3:0] S_EXP   = 4'd3;
  localparam logic [3:0] S_MULR  = 4'd4;
  localparam logic [3:0] S_MULB  = 4'd5;
  localparam logic [3:0] S_SQCHK = 4'd6;
  localparam logic [3:0] S_SQ    = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]    state;
  logic          passing;
  logic          round_ok;
  logic          last_q;
  mr_pkg::word_t p_q;
  mr_pkg::word_t a_q;
  mr_pkg::word_t pm1;
  mr_pkg::word_t e_q;
  mr_pkg::word_t x_q;
  mr_pkg::word_t base_q;
  mr_pkg::cnt_t  r_q;
  mr_pkg::cnt_t  j_q;

  logic          red_start;
  logic          red_done;
  mr_pkg::word_t red_rem;
  logic          mul_start;
  logic          mul_done;
  mr_pkg::word_t mul_x;
  mr_pkg::word_t mul_y;
  mr_pkg::word_t mul_res;
  logic          trivial_fail;
  logic          sq_more;
  logic          fin_go;

  assign in_stall = (state != S_IDLE);
  assign trivial_fail = (candidate[mr_pkg::WORD_BITS-1:1] == '0)
                     || (candidate != mr_pkg::WORD_BITS'(2) && !candidate[0]);
  assign sq_more = (j_q != r_q) && (x_q != mr_pkg::WORD_BITS'(1)) && (x_q != pm1);
  assign fin_go = !last_q || !out_valid || !out_stall;

  assign red_start = (state == S_STRIP) && e_q[0];
  assign mul_start = (state == S_EXP && e_q != '0)
                  || (state == S_MULR && mul_done)
                  || (state == S_SQCHK && sq_more);
  assign mul_x = ((state == S_EXP && e_q[0]) || state == S_SQCHK) ? x_q : base_q;
  assign mul_y = (state == S_SQCHK) ? x_q : base_q;

  mr_modred u_red (
    .clk   (clk),
    .rst   (rst),
    .start (red_start),
    .a     (a_q),
    .m     (p_q),
    .done  (red_done),
    .rem   (red_rem)
  );

  mr_modmul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .m     (p_q),
    .done  (mul_done),
    .acc   (mul_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      passing   <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !(state == S_FIN && last_q)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            p_q      <= candidate;
            a_q      <= witness;
            last_q   <= last_round;
            pm1      <= candidate - 1'b1;
            e_q      <= candidate - 1'b1;
            r_q      <= '0;
            j_q      <= '0;
            round_ok <= !trivial_fail;
            state    <= trivial_fail ? S_FIN : S_STRIP;
          end
        end
        S_STRIP: begin
          // strip trailing zeros of candidate-1, leaving the odd part in e_q
          if (e_q[0]) begin
            state <= S_RED;
          end else begin
            e_q <= {1'b0, e_q[mr_pkg::WORD_BITS-1:1]};
            r_q <= r_q + 1'b1;
          end
        end
        S_RED: begin
          if (red_done) begin
            base_q <= red_rem;
            x_q    <= mr_pkg::WORD_BITS'(1);
            state  <= S_EXP;
          end
        end
        S_EXP: begin
          if (e_q == '0) state <= S_SQCHK;
          else state <= e_q[0] ? S_MULR : S_MULB;
        end
        S_MULR: begin
          if (mul_done) begin
            x_q   <= mul_res;
            state <= S_MULB;
          end
        end
        S_MULB: begin
          if (mul_done) begin
            base_q <= mul_res;
            e_q    <= {1'b0, e_q[mr_pkg::WORD_BITS-1:1]};
            state  <= S_EXP;
          end
        end
        S_SQCHK: begin
          if (sq_more) begin
            state <= S_SQ;
          end else begin
            round_ok <= !(x_q != pm1 && j_q != '0);
            state    <= S_FIN;
          end
        end
        S_SQ: begin
          if (mul_done) begin
            x_q   <= mul_res;
            j_q   <= j_q + 1'b1;
            state <= S_SQCHK;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            if (last_q) begin
              probably_prime <= passing && round_ok;
              out_valid      <= 1'b1;
              passing        <= 1'b1;
            end else begin
              passing <= passing && round_ok;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_mul_done_waiting: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_MULR || state == S_MULB || state == S_SQ || state == S_SQCHK
                  || state == S_EXP))
    else $error("multiplier finished outside a multiply wait");

  a_red_done_waiting: assert property (@(posedge clk) disable iff (rst)
    red_done |-> (state == S_RED || state == S_EXP))
    else $error("reduction finished outside its wait");

  a_square_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQCHK) |-> (j_q <= r_q))
    else $error("squaring count passed the stripped zero count");

  a_flag_rearmed: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && fin_go && last_q) |=> (passing && out_valid))
    else $error("last round did not emit and rearm the flag");

endmodule
